// ===== rtl/core/fekv_pkg.sv =====
// Package for the FIFO-evicting key/value table: opcodes, entry layout,
// default sizes and the byte helpers. No dependencies.
package fekv_pkg;

  // default sizes
  localparam int DEF_ENTRIES     = 32;
  localparam int DEF_VALUE_LIMIT = 9;
  localparam int DEF_KEY_LIMIT   = 9;

  // floor(x / 100) as (x * THR_MUL) >> THR_SHIFT, exact for x up to 255 * 127
  localparam int PERCENT_SCALE = 100;
  localparam int THR_SHIFT     = 21;
  localparam int THR_MUL       = ((1 << THR_SHIFT) + PERCENT_SCALE - 1) / PERCENT_SCALE;

  localparam int CLEAN_RESET = 80;

  // register index on the configuration port
  localparam logic REG_CLEAN_PERCENT = 1'b0;

  typedef enum logic [2:0] {
    OP_SET_STR    = 3'd0,
    OP_SET_BIN    = 3'd1,
    OP_GET_ANY    = 3'd2,
    OP_GET_STR    = 3'd3,
    OP_GET_BIN    = 3'd4,
    OP_DELETE     = 3'd5,
    OP_AUTO_CLEAN = 3'd6,
    OP_ERASE_ALL  = 3'd7
  } op_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic [3:0]  len;
    logic        typ;
  } entry_t;

  // mask of the low n bytes (all ones for n of 8 or more)
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // keep characters before the first zero byte, at most max_chars of them
  function automatic logic [63:0] text_word(input logic [63:0] w, input logic [3:0] max_chars);
    logic [63:0] r;
    logic        keep;
    r    = '0;
    keep = 1'b1;
    for (int b = 0; b < 8; b++) begin
      keep = keep && (4'(b) < max_chars) && (w[8*b +: 8] != 8'h00);
      if (keep) r[8*b +: 8] = w[8*b +: 8];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/fekv_mem.sv =====
// Entry memory of the key/value table: one write port, one read port,
// registered read data. Uses fekv_pkg for the entry layout.
module fekv_mem
  import fekv_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fekv_cfg.sv =====
// Configuration port of the key/value table: clean_percent register and
// the trim threshold derived from it. Uses fekv_pkg.
module fekv_cfg
  import fekv_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  localparam int TW = $clog2(ENTRIES * 127 / 100 + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output logic [TW-1:0] threshold
);

  localparam int KW = $clog2(ENTRIES * THR_MUL + 1);
  localparam int PW = KW + 7;
  localparam logic [PW-1:0] THR_K = PW'(ENTRIES * THR_MUL);

  logic [6:0]    clean_percent;
  logic [PW-1:0] prod;

  assign pready = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      clean_percent <= 7'(CLEAN_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == REG_CLEAN_PERCENT)) begin
      clean_percent <= pwdata[6:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CLEAN_PERCENT) prdata = 32'(clean_percent);
  end

  // threshold = floor(ENTRIES * clean_percent / 100), registered
  assign prod = PW'(clean_percent) * THR_K;

  always_ff @(posedge clk) begin
    threshold <= TW'(prod >> THR_SHIFT);
  end

endmodule

// ===== rtl/core/fifo_evicting_key_value_table_core.sv =====
// Top level of the FIFO-evicting key/value table: sequencer over the entry
// memory. Uses fekv_pkg, fekv_mem and fekv_cfg.
//
// Usage: a command word (opcode, entry_key, payload, payload_bytes,
// buffer_bytes) is taken at a clock edge where start is high and busy is
// low. Exactly one result word follows, shown for one cycle while done is
// high: status, read_value, read_length, read_type and fill_count. The
// receiver cannot stall; the result is simply presented once.
// Entries sit packed in a one-port-read, one-port-write memory, oldest at
// slot 0. A lookup reads one slot per cycle; a delete or trim moves the
// surviving entries down one per cycle and a new key is then appended in
// S_APPEND. An erase-all or a rejected set completes straight from idle.
// clean_percent is to be written over the APB port at byte address 0 only
// while idle; the block itself does not enforce this. The derived threshold
// is registered from the clean_percent register.
// Reset empties the table (fill count to zero) and sets clean_percent to 80;
// memory is not cleared, since data from slots beyond the fill is never used.
module fifo_evicting_key_value_table_core
  import fekv_pkg::*;
#(
  parameter int ENTRIES     = DEF_ENTRIES,
  parameter int VALUE_LIMIT = DEF_VALUE_LIMIT,
  parameter int KEY_LIMIT   = DEF_KEY_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [63:0] entry_key,
  input  logic [63:0] payload,
  input  logic [3:0]  payload_bytes,
  input  logic [3:0]  buffer_bytes,
  output logic        done,
  output logic        status,
  output logic [63:0] read_value,
  output logic [3:0]  read_length,
  output logic        read_type,
  output logic [5:0]  fill_count
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = $clog2(ENTRIES * 127 / 100 + 1);
  localparam int XW = (CW > TW) ? CW : TW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MISS,
    S_SHIFT,
    S_APPEND
  } state_t;

  state_t         state;
  op_t            op;
  logic [63:0]    key;
  logic [63:0]    val;
  logic [3:0]     len;
  logic [3:0]     blen;
  logic [CW-1:0]  used;
  logic [CW-1:0]  sa;
  logic [CW-1:0]  rd_idx;
  logic           pend;
  logic [CW-1:0]  rptr;
  logic [CW-1:0]  wptr;
  logic [CW-1:0]  gap;
  logic [TW-1:0]  threshold;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  entry_t         mem_wdata;
  logic [AW-1:0]  mem_raddr;
  entry_t         mem_rdata;

  logic           is_set;
  logic           hit;
  logic           get_ok;
  logic           over_thr;
  logic [CW-1:0]  trim_d;
  logic [CW-1:0]  set_d;
  logic           full;
  op_t            op_in;

  fekv_cfg #(.ENTRIES(ENTRIES)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  fekv_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy       = (state != S_IDLE);
  assign fill_count = 6'(used);
  assign op_in      = op_t'(opcode);

  // decode helpers
  assign is_set   = (op == OP_SET_STR) || (op == OP_SET_BIN);
  assign hit      = pend && (mem_rdata.key == key);
  assign get_ok   = (blen >= mem_rdata.len) &&
                    ((op == OP_GET_ANY) || (mem_rdata.typ == (op == OP_GET_BIN)));
  assign over_thr = XW'(used) > XW'(threshold);
  assign trim_d   = over_thr ? CW'(XW'(used) - XW'(threshold)) : '0;
  assign full     = (used == CW'(ENTRIES));
  assign set_d    = ((op == OP_SET_STR) && over_thr) ? trim_d :
                    (full ? CW'(1) : '0);

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    case (state)
      S_SEARCH: begin
        mem_raddr = sa[AW-1:0];
        // in-place update of an existing key
        if (hit && is_set) begin
          mem_we          = 1'b1;
          mem_waddr       = rd_idx[AW-1:0];
          mem_wdata.value = val;
          mem_wdata.len   = len;
          mem_wdata.typ   = (op == OP_SET_BIN);
        end
      end
      S_SHIFT: begin
        mem_raddr = rptr[AW-1:0];
        mem_we    = pend;
        mem_waddr = wptr[AW-1:0];
      end
      S_APPEND: begin
        mem_we          = 1'b1;
        mem_waddr       = used[AW-1:0];
        mem_wdata.key   = text_word(key, 4'(KEY_LIMIT - 1));
        mem_wdata.value = val;
        mem_wdata.len   = len;
        mem_wdata.typ   = (op == OP_SET_BIN);
      end
      default: ;
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op          <= op_in;
            key         <= text_word(entry_key, 4'd8);
            val         <= payload & byte_mask(payload_bytes);
            len         <= payload_bytes;
            blen        <= buffer_bytes;
            sa          <= '0;
            pend        <= 1'b0;
            status      <= 1'b1;
            read_value  <= '0;
            read_length <= '0;
            read_type   <= 1'b0;
            if (((op_in == OP_SET_STR) || (op_in == OP_SET_BIN)) &&
                ((payload_bytes >= 4'(VALUE_LIMIT)) ||
                 ((op_in == OP_SET_BIN) && (payload_bytes == 4'd0)))) begin
              done <= 1'b1;
            end else if (op_in == OP_ERASE_ALL) begin
              used   <= '0;
              status <= 1'b0;
              done   <= 1'b1;
            end else if (op_in == OP_AUTO_CLEAN) begin
              if (over_thr) begin
                gap   <= trim_d;
                rptr  <= trim_d;
                wptr  <= '0;
                state <= S_SHIFT;
              end else begin
                status <= 1'b0;
                done   <= 1'b1;
              end
            end else if (used == '0) begin
              state <= S_MISS;
            end else begin
              state <= S_SEARCH;
            end
          end
        end

        S_SEARCH: begin
          if (hit) begin
            pend <= 1'b0;
            if (is_set) begin
              status <= 1'b0;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else if (op == OP_DELETE) begin
              gap   <= CW'(1);
              rptr  <= rd_idx + CW'(1);
              wptr  <= rd_idx;
              state <= S_SHIFT;
            end else begin
              if (get_ok) begin
                status      <= 1'b0;
                read_value  <= mem_rdata.value & byte_mask(mem_rdata.len);
                read_length <= mem_rdata.len;
                read_type   <= mem_rdata.typ;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else if (pend && (rd_idx == used - CW'(1))) begin
            pend  <= 1'b0;
            state <= S_MISS;
          end else begin
            rd_idx <= sa;
            pend   <= 1'b1;
            sa     <= sa + CW'(1);
          end
        end

        S_MISS: begin
          if (is_set) begin
            if (set_d != '0) begin
              gap   <= set_d;
              rptr  <= set_d;
              wptr  <= '0;
              state <= S_SHIFT;
            end else begin
              state <= S_APPEND;
            end
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        // move entries down by gap, one per cycle
        S_SHIFT: begin
          if (pend) wptr <= wptr + CW'(1);
          if (rptr < used) begin
            pend <= 1'b1;
            rptr <= rptr + CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              used <= used - gap;
              if (is_set) begin
                state <= S_APPEND;
              end else begin
                status <= 1'b0;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
          end
        end

        S_APPEND: begin
          used   <= used + CW'(1);
          status <= 1'b0;
          done   <= 1'b1;
          state  <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
